>>> design/srld_pkg.sv
// Shared types and constants for the sprite run-length line decoder.
`default_nettype none
package srld_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [7:0] LIT_HEADER = 8'hFF;
	localparam logic [2:0] LIT_TYPE   = 3'h7;

	// decoder phase
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_LENGTH  = 2'd1;
	localparam logic [1:0] PH_LITERAL = 2'd2;

	// format modes; the remaining codes decode as packed runs per row
	localparam logic [1:0] MODE_PAIR  = 2'd0;
	localparam logic [1:0] MODE_CHUNK = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FORMAT_MODE  = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	// one classified input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       line_start;
		logic       frame_start;
		logic       hdr_lit;   // byte is the literal header of a byte pair
		logic       pk_lit;    // packed byte has the literal type
	} item_t;

endpackage
`default_nettype wire

>>> design/srld_front.sv
// Input stage: takes byte transfers, classifies them and feeds the queue.
`default_nettype none
module srld_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [7:0]          s_tdata,   // data_byte
	input  wire  [1:0]          s_tuser,   // line_start, frame_start
	output logic                q_valid,
	input  wire                 q_ready,
	output srld_pkg::item_t     q_item
);

	logic            vld_s1;
	srld_pkg::item_t item_s1;
	srld_pkg::item_t item_d;

	always_comb begin
		item_d.data_byte   = s_tdata;
		item_d.line_start  = s_tuser[0];
		item_d.frame_start = s_tuser[1];
		item_d.hdr_lit     = (s_tdata == srld_pkg::LIT_HEADER);
		item_d.pk_lit      = (s_tdata[7:5] == srld_pkg::LIT_TYPE);
	end

	assign s_tready = !vld_s1 || q_ready;
	assign q_valid  = vld_s1;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

>>> design/srld_queue.sv
// Short queue of classified bytes between the front and the decoder.
`default_nettype none
module srld_queue #(
	parameter int DEPTH = srld_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  srld_pkg::item_t     in_item,
	output logic                out_valid,
	input  wire                 out_ready,
	output srld_pkg::item_t     out_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	srld_pkg::item_t  mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

endmodule
`default_nettype wire

>>> design/srld_back.sv
// Decoder: line/run state, configuration registers and the result register.
`default_nettype none
module srld_back #(
	parameter int COORD_BITS = srld_pkg::COORD_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     q_valid,
	output logic                    q_ready,
	input  srld_pkg::item_t         q_item,
	input  wire                     cfg_valid,
	input  wire  [1:0]              cfg_index,
	input  wire  [COORD_BITS-1:0]   cfg_data,
	output logic                    res_valid,
	input  wire                     res_ready,
	output logic [7:0]              pixel_index,
	output logic [COORD_BITS-1:0]   row,
	output logic [COORD_BITS-1:0]   column,
	output logic [8:0]              run_length,
	output logic                    is_error
);

	localparam int C = COORD_BITS;

	logic [1:0]   mode_q;
	logic [C-1:0] fw_q;
	logic [C-1:0] fh_q;

	logic [1:0]   phase_q;
	logic [7:0]   hdr_q;
	logic         hdr_lit_q;
	logic [8:0]   left_q;
	logic [C-1:0] col_q;
	logic [C-1:0] row_q;
	logic         hold_q;

	logic         out_vld_q;
	logic [7:0]   pix_q;
	logic [C-1:0] orow_q;
	logic [C-1:0] ocol_q;
	logic [8:0]   olen_q;
	logic         oerr_q;

	logic [1:0]   n_phase;
	logic [7:0]   n_hdr;
	logic         n_hdr_lit;
	logic [8:0]   n_left;
	logic [8:0]   left_dec;
	logic [C-1:0] n_col;
	logic [C-1:0] n_row;
	logic         n_hold;
	logic [C-1:0] row_inc;
	logic         do_run;
	logic         run_lit;
	logic [7:0]   run_val;
	logic [8:0]   len_run;
	logic [C:0]   span;
	logic         r_vld;
	logic [7:0]   r_pix;
	logic [C-1:0] r_row;
	logic [C-1:0] r_col;
	logic [8:0]   r_len;
	logic         r_err;
	logic         out_free;
	logic         pop;

	assign out_free = !out_vld_q || res_ready;
	assign q_ready  = out_free;
	assign pop      = q_valid && out_free;

	always_comb begin
		n_phase   = phase_q;
		n_hdr     = hdr_q;
		n_hdr_lit = hdr_lit_q;
		n_left    = left_q;
		left_dec  = '0;
		n_col     = col_q;
		n_row     = row_q;
		n_hold    = hold_q;
		row_inc   = row_q + 1'b1;
		do_run    = 1'b0;
		run_lit   = 1'b0;
		run_val   = '0;
		len_run   = '0;
		span      = '0;
		r_vld     = 1'b0;
		r_pix     = '0;
		r_row     = row_q;
		r_col     = col_q;
		r_len     = '0;
		r_err     = 1'b0;

		if (q_item.frame_start) begin
			n_row   = '0;
			n_col   = '0;
			n_hold  = 1'b0;
			n_phase = srld_pkg::PH_HEADER;
			n_left  = '0;
		end else if (q_item.line_start && !hold_q) begin
			n_phase = srld_pkg::PH_HEADER;
			n_left  = '0;
			if (mode_q == srld_pkg::MODE_CHUNK) begin
				// a chunk starts a new row only once the row is full
				if (col_q == fw_q) begin
					n_row = row_inc;
					n_col = '0;
					if (row_inc > fh_q) begin
						n_hold = 1'b1;
						r_vld  = 1'b1;
						r_row  = row_inc;
						r_col  = '0;
						r_err  = 1'b1;
					end
				end
			end else begin
				n_row = row_inc;
				n_col = '0;
			end
		end

		if (!n_hold) begin
			case (n_phase)
				srld_pkg::PH_LITERAL: begin
					r_vld    = 1'b1;
					r_pix    = q_item.data_byte;
					r_row    = n_row;
					r_col    = n_col;
					r_len    = 9'd1;
					n_col    = n_col + 1'b1;
					left_dec = (n_left != '0) ? n_left - 1'b1 : n_left;
					n_left   = left_dec;
					if (left_dec == '0) begin
						n_phase = srld_pkg::PH_HEADER;
					end
				end
				srld_pkg::PH_LENGTH: begin
					do_run  = 1'b1;
					run_val = hdr_q;
					run_lit = hdr_lit_q;
					len_run = {1'b0, q_item.data_byte} + 9'd1;
				end
				default: begin
					if (mode_q == srld_pkg::MODE_PAIR) begin
						n_hdr     = q_item.data_byte;
						n_hdr_lit = q_item.hdr_lit;
						n_phase   = srld_pkg::PH_LENGTH;
					end else begin
						do_run  = 1'b1;
						run_val = {5'b0, q_item.data_byte[7:5]};
						run_lit = q_item.pk_lit;
						len_run = {4'b0, q_item.data_byte[4:0]} + 9'd1;
					end
				end
			endcase

			if (do_run) begin
				span = {1'b0, n_col} + {{(C-8){1'b0}}, len_run};
				if (span > {1'b0, fw_q}) begin
					n_hold  = 1'b1;
					n_phase = srld_pkg::PH_HEADER;
					n_left  = '0;
					r_vld   = 1'b1;
					r_row   = n_row;
					r_col   = n_col;
					r_len   = len_run;
					r_err   = 1'b1;
				end else if (run_lit) begin
					n_left  = len_run;
					n_phase = srld_pkg::PH_LITERAL;
				end else begin
					r_vld   = 1'b1;
					r_pix   = run_val;
					r_row   = n_row;
					r_col   = n_col;
					r_len   = len_run;
					n_col   = span[C-1:0];
					n_phase = srld_pkg::PH_HEADER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= srld_pkg::MODE_PAIR;
			fw_q      <= '0;
			fh_q      <= '0;
			phase_q   <= srld_pkg::PH_HEADER;
			hdr_q     <= '0;
			hdr_lit_q <= 1'b0;
			left_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
			hold_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					srld_pkg::REG_FORMAT_MODE:  mode_q <= cfg_data[1:0];
					srld_pkg::REG_FRAME_WIDTH:  fw_q   <= cfg_data;
					srld_pkg::REG_FRAME_HEIGHT: fh_q   <= cfg_data;
					default: ;
				endcase
			end
			if (pop) begin
				phase_q   <= n_phase;
				hdr_q     <= n_hdr;
				hdr_lit_q <= n_hdr_lit;
				left_q    <= n_left;
				col_q     <= n_col;
				row_q     <= n_row;
				hold_q    <= n_hold;
			end
			if (out_free) begin
				out_vld_q <= pop && r_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && r_vld) begin
			pix_q  <= r_pix;
			orow_q <= r_row;
			ocol_q <= r_col;
			olen_q <= r_len;
			oerr_q <= r_err;
		end
	end

	assign res_valid   = out_vld_q;
	assign pixel_index = pix_q;
	assign row         = orow_q;
	assign column      = ocol_q;
	assign run_length  = olen_q;
	assign is_error    = oerr_q;

	// a literal run in progress always has bytes left
	a_lit_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == srld_pkg::PH_LITERAL |-> left_q != '0)
		else $error("literal phase with no bytes left");

	// after an error only a frame start may produce anything
	a_hold_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		pop && hold_q && !q_item.frame_start |-> !r_vld)
		else $error("result produced while error hold is set");

	a_err_pix: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && oerr_q |-> pix_q == '0)
		else $error("error result carries a pixel value");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !oerr_q |-> olen_q != '0)
		else $error("pixel run of zero length");

endmodule
`default_nettype wire

>>> design/sprite_rle_line_decoder.sv
// Top level of the sprite run-length line decoder.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata: data_byte; s_tuser: line_start, frame_start
//  m_*      out  m_tvalid / m_tready    m_tdata: pixel_index, row, column, run_length;
//                                       m_tuser: is_error
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained while m_tready does not stall; a run result passes the
// input register, the queue and the result register before it is offered.
// The decoder state updates once per byte, which sets that rate.
// Reset clears all control state; configuration resets to zero.
// A stalled m_tready fills the queue before s_tready drops.
`default_nettype none
module sprite_rle_line_decoder #(
	parameter int COORD_BITS = srld_pkg::COORD_BITS_DEF,
	localparam int FIELD_W   = 8 + 2 * COORD_BITS + 9,
	localparam int OUT_W     = ((FIELD_W + 7) / 8) * 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire  [7:0]              s_tdata,   // data_byte
	input  wire  [1:0]              s_tuser,   // line_start, frame_start
	output logic                    m_tvalid,
	input  wire                     m_tready,
	// pixel_index, row, column, run_length, zero fill
	output logic [OUT_W-1:0]        m_tdata,
	output logic [0:0]              m_tuser,   // is_error
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [1:0]              cfg_index,
	input  wire  [COORD_BITS-1:0]   cfg_data
);

	logic                  q_in_valid;
	logic                  q_in_ready;
	srld_pkg::item_t       q_in_item;
	logic                  q_out_valid;
	logic                  q_out_ready;
	srld_pkg::item_t       q_out_item;
	logic [7:0]            pixel_index;
	logic [COORD_BITS-1:0] row;
	logic [COORD_BITS-1:0] column;
	logic [8:0]            run_length;
	logic                  is_error;

	assign cfg_ready = 1'b1;

	srld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_in_valid),
		.q_ready  (q_in_ready),
		.q_item   (q_in_item)
	);

	srld_queue #(
		.DEPTH (srld_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_in_valid),
		.in_ready  (q_in_ready),
		.in_item   (q_in_item),
		.out_valid (q_out_valid),
		.out_ready (q_out_ready),
		.out_item  (q_out_item)
	);

	srld_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_out_valid),
		.q_ready     (q_out_ready),
		.q_item      (q_out_item),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.pixel_index (pixel_index),
		.row         (row),
		.column      (column),
		.run_length  (run_length),
		.is_error    (is_error)
	);

	assign m_tdata = {{(OUT_W - FIELD_W){1'b0}}, run_length, column, row, pixel_index};
	assign m_tuser = is_error;

endmodule
`default_nettype wire

>>> test/sprite_rle_line_decoder_tb.sv
// Self-checking testbench for the sprite run-length line decoder.
`timescale 1ns / 1ps
module sprite_rle_line_decoder_tb;

	localparam int CLK_HALF    = 5;
	localparam int DRAIN_WAIT  = 12;    // result path is three registers deep
	localparam int LONG_HOLD   = 300;
	localparam int STALL_LIMIT = 4000;

	// format codes with no name in the package
	localparam logic [1:0] MODE_ROWS     = 2'd1;
	localparam logic [1:0] MODE_ROWS_ALT = 2'd3;

	typedef struct {
		logic [7:0] pix;
		logic [9:0] row;
		logic [9:0] col;
		logic [8:0] len;
		logic       err;
	} pixel_run_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;     // data_byte
	logic [1:0]  s_tuser;     // line_start, frame_start
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;     // pixel_index, row, column, run_length, zero fill
	logic [0:0]  m_tuser;     // is_error
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;

	// decoder state as the testbench sees it
	logic [1:0]  cur_mode   = srld_pkg::MODE_PAIR;
	logic [9:0]  fwidth     = '0;
	logic [9:0]  fheight    = '0;
	logic [1:0]  ph         = srld_pkg::PH_HEADER;
	logic [7:0]  hdr        = '0;
	int          lit_left   = 0;
	logic [9:0]  col        = '0;
	logic [9:0]  row        = '0;
	bit          err_hold   = 1'b0;

	pixel_run_t  runs_due[$];

	bit src_gaps  = 1'b1;
	bit snk_gaps  = 1'b1;
	bit hold_req  = 1'b0;
	int mismatches = 0;
	int bytes_sent = 0;
	int runs_seen  = 0;
	int errs_seen  = 0;
	int cfg_sets   = 0;
	int quiet_cycles = 0;

	sprite_rle_line_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------- prediction

	function automatic void open_run(logic [7:0] val, bit lit, int len);
		if (int'(col) + len > int'(fwidth)) begin
			err_hold = 1'b1;
			ph       = srld_pkg::PH_HEADER;
			lit_left = 0;
			runs_due.push_back('{8'd0, row, col, 9'(len), 1'b1});
		end else if (lit) begin
			lit_left = len;
			ph       = srld_pkg::PH_LITERAL;
		end else begin
			runs_due.push_back('{val, row, col, 9'(len), 1'b0});
			col = 10'(int'(col) + len);
			ph  = srld_pkg::PH_HEADER;
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic ls, logic fs);
		logic [7:0] pk;
		if (fs) begin
			row      = '0;
			col      = '0;
			err_hold = 1'b0;
			ph       = srld_pkg::PH_HEADER;
			lit_left = 0;
		end else if (ls && !err_hold) begin
			ph       = srld_pkg::PH_HEADER;
			lit_left = 0;
			if (cur_mode == srld_pkg::MODE_CHUNK) begin
				// chunk mode advances only once the row is full
				if (col == fwidth) begin
					row = row + 10'd1;
					col = '0;
					if (row > fheight) begin
						err_hold = 1'b1;
						runs_due.push_back('{8'd0, row, 10'd0, 9'd0, 1'b1});
						return;
					end
				end
			end else begin
				row = row + 10'd1;
				col = '0;
			end
		end
		if (err_hold)
			return;
		if (ph == srld_pkg::PH_LITERAL) begin
			runs_due.push_back('{b, row, col, 9'd1, 1'b0});
			col = col + 10'd1;
			if (lit_left > 0)
				lit_left--;
			if (lit_left == 0)
				ph = srld_pkg::PH_HEADER;
			return;
		end
		if (ph == srld_pkg::PH_LENGTH) begin
			open_run(hdr, hdr == srld_pkg::LIT_HEADER, int'(b) + 1);
			return;
		end
		if (cur_mode == srld_pkg::MODE_PAIR) begin
			hdr = b;
			ph  = srld_pkg::PH_LENGTH;
			return;
		end
		pk = {5'd0, b[7:5]};
		open_run(pk, b[7:5] == srld_pkg::LIT_TYPE, int'(b[4:0]) + 1);
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		pixel_run_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (runs_due.size() == 0) begin
				$error("result with no expectation waiting: tdata %h tuser %b",
					m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = runs_due.pop_front();
				check_field("pixel_index", 32'(want.pix), 32'(m_tdata[7:0]));
				check_field("row",         32'(want.row), 32'(m_tdata[17:8]));
				check_field("column",      32'(want.col), 32'(m_tdata[27:18]));
				check_field("run_length",  32'(want.len), 32'(m_tdata[36:28]));
				check_field("is_error",    32'(want.err), 32'(m_tuser[0]));
				if (want.err)
					errs_seen++;
				else
					runs_seen++;
			end
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (snk_gaps && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// watchdog: ends the run when nothing transfers for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					quiet_cycles, runs_due.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic send_byte(logic [7:0] b, logic ls, logic fs);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= {fs, ls};
		do @(posedge clk); while (!s_tready);
		decode_byte(b, ls, fs);
		bytes_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			srld_pkg::REG_FORMAT_MODE:  cur_mode = val[1:0];
			srld_pkg::REG_FRAME_WIDTH:  fwidth   = val;
			srld_pkg::REG_FRAME_HEIGHT: fheight  = val;
			default: ;
		endcase
	endtask

	// only called with the decoder idle
	task automatic set_config(logic [1:0] m, logic [9:0] w, logic [9:0] h);
		write_reg(srld_pkg::REG_FORMAT_MODE, {8'd0, m});
		write_reg(srld_pkg::REG_FRAME_WIDTH, w);
		write_reg(srld_pkg::REG_FRAME_HEIGHT, h);
		cfg_valid <= 1'b0;
		cfg_sets++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (runs_due.size() != 0)
			@(posedge clk);
		// a header byte has no result but may still be in flight
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_len(int room, int maxlen);
		int hi;
		if (room >= 1 && $urandom_range(0, 9) != 0) begin
			hi = (room < maxlen) ? room : maxlen;
			return 8'($urandom_range(0, hi - 1));
		end
		return 8'($urandom_range(0, maxlen - 1));
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_pair_mode();
		set_config(srld_pkg::MODE_PAIR, 10'd1023, 10'd1023);
		send_byte(8'h05, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);    // fill of the longest length
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(srld_pkg::LIT_HEADER, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(srld_pkg::LIT_HEADER, 1'b0, 1'b0);
		send_byte(8'h7E, 1'b1, 1'b0);    // line start drops the open segment
		send_byte(8'h03, 1'b0, 1'b0);
		wait_idle();
	endtask

	task automatic test_packed_rows();
		set_config(MODE_ROWS, 10'd40, 10'd3);
		send_byte(8'h1F, 1'b0, 1'b1);
		send_byte(8'hE2, 1'b0, 1'b0);
		send_byte(8'hAA, 1'b0, 1'b0);
		send_byte(8'h55, 1'b1, 1'b0);    // line start cuts the literal short
		send_byte(8'h3F, 1'b0, 1'b0);    // passes the width
		send_byte(8'h00, 1'b1, 1'b0);    // ignored while in error
		send_byte(8'h10, 1'b0, 1'b1);
		wait_idle();
	endtask

	task automatic test_chunk_rows();
		set_config(srld_pkg::MODE_CHUNK, 10'd64, 10'd1);
		send_byte(8'h1F, 1'b0, 1'b1);
		send_byte(8'h5F, 1'b1, 1'b0);    // row not full: stays on row 0
		send_byte(8'h20, 1'b1, 1'b0);    // row full: moves to row 1
		send_byte(8'hE1, 1'b1, 1'b0);
		send_byte(8'h9C, 1'b0, 1'b0);
		send_byte(8'h07, 1'b0, 1'b0);
		send_byte(8'h1F, 1'b1, 1'b0);
		send_byte(8'h3C, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);    // row 2 passes the height
		send_byte(8'h45, 1'b0, 1'b0);
		wait_idle();
	endtask

	task automatic test_zero_width();
		set_config(MODE_ROWS_ALT, 10'd0, 10'd0);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b0);
		wait_idle();
	endtask

	// phase carries across a format change
	task automatic test_mode_switch();
		set_config(srld_pkg::MODE_PAIR, 10'd1023, 10'd0);
		send_byte(srld_pkg::LIT_HEADER, 1'b0, 1'b1);
		send_byte(8'h02, 1'b0, 1'b0);
		send_byte(8'h11, 1'b0, 1'b0);
		wait_idle();
		set_config(MODE_ROWS, 10'd1023, 10'd1023);
		send_byte(8'h22, 1'b0, 1'b0);
		send_byte(8'h33, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		wait_idle();
	endtask

	// back to back line starts, one fill run per row
	task automatic test_line_steps();
		int i;
		set_config(MODE_ROWS, 10'd1023, 10'd1023);
		send_byte(8'h00, 1'b0, 1'b1);
		for (i = 0; i < 64; i++)
			send_byte(8'($urandom_range(0, 6) << 5), 1'b1, 1'b0);
		wait_idle();
	endtask

	task automatic test_backpressure();
		int i;
		set_config(MODE_ROWS, 10'd1023, 10'd1023);
		hold_req = 1'b1;
		send_byte(8'h00, 1'b0, 1'b1);
		for (i = 0; i < 40; i++)
			send_byte(8'($urandom_range(0, 6) << 5), 1'b0, 1'b0);
		wait_idle();
	endtask

	task automatic run_random(int n);
		int         done;
		int         room;
		logic [7:0] b;
		logic       ls;
		logic       fs;
		logic [9:0] base;
		logic [1:0] next_ph;
		logic [2:0] kind;
		done = 0;
		send_byte(8'($urandom), 1'b0, 1'b1);
		while (done < n) begin
			fs = err_hold ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 79) == 0);
			ls = 1'b0;
			if (err_hold && !fs)
				ls = 1'($urandom_range(0, 1));
			else if (!fs)
				ls = (ph == srld_pkg::PH_HEADER && col == fwidth) ||
					$urandom_range(0, 11) == 0;
			if (fs || (ls && (cur_mode != srld_pkg::MODE_CHUNK || col == fwidth)))
				base = '0;
			else
				base = col;
			room = int'(fwidth) - int'(base);
			next_ph = (fs || ls) ? srld_pkg::PH_HEADER : ph;
			if ((err_hold && !fs) || next_ph == srld_pkg::PH_LITERAL) begin
				b = 8'($urandom);
			end else if (next_ph == srld_pkg::PH_LENGTH) begin
				b = pick_len(room, 256);
			end else if (cur_mode == srld_pkg::MODE_PAIR) begin
				b = ($urandom_range(0, 3) == 0) ? srld_pkg::LIT_HEADER :
					8'($urandom_range(0, 254));
			end else begin
				kind = ($urandom_range(0, 3) == 0) ? srld_pkg::LIT_TYPE :
					3'($urandom_range(0, 6));
				b = pick_len(room, 32);
				b[7:5] = kind;
			end
			if ($urandom_range(0, 9) == 0)
				b = 8'($urandom);
			if (!(err_hold && !fs))
				done++;
			send_byte(b, ls, fs);
		end
	endtask

	task automatic test_random_frames();
		int         k;
		logic [1:0] m;
		logic [9:0] w;
		logic [9:0] h;
		for (k = 0; k < 10; k++) begin
			if (k >= 7) begin
				src_gaps = 1'b0;
				snk_gaps = 1'b0;
			end
			case (k % 3)
				0:       m = srld_pkg::MODE_PAIR;
				1:       m = MODE_ROWS;
				default: m = srld_pkg::MODE_CHUNK;
			endcase
			case (k % 4)
				0:       w = 10'd1023;
				1:       w = 10'($urandom_range(1, 128));
				2:       w = 10'(32 * $urandom_range(1, 8));
				default: w = 10'($urandom_range(0, 1023));
			endcase
			case (k % 3)
				0:       h = 10'($urandom_range(1, 12));
				1:       h = 10'd1023;
				default: h = 10'd0;
			endcase
			set_config(m, w, h);
			run_random(30);
			wait_idle();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = srld_pkg::REG_FORMAT_MODE;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pair_mode();
		test_packed_rows();
		test_chunk_rows();
		test_zero_width();
		test_mode_switch();
		test_line_steps();
		test_backpressure();
		test_random_frames();

		wait_idle();
		$display("summary: %0d bytes sent over %0d register settings in all three formats",
			bytes_sent, cfg_sets);
		$display("summary: %0d runs and %0d error results checked, %0d mismatches",
			runs_seen, errs_seen, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
